// ===== rtl/ntc_pkg.sv =====
// Shared constants for the thermistor table temperature converter.
// Holds the descending calibration ROM, the field widths and the divider sizing.
// No dependencies.
package ntc_pkg;

  localparam int TABLE_ENTRIES = 161;
  localparam int FIRST_DEGREE  = -40;

  localparam int RAW_W    = 12;
  localparam int TEMP_W   = 12;
  localparam int FRAC_SH  = 4;
  localparam int X_W      = RAW_W + FRAC_SH;
  localparam int ROM_W    = 16;
  localparam int IDX_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int FRAC_W   = FRAC_SH + 1;
  localparam int DIV_STEPS = FRAC_W;
  localparam int STEP_W   = $clog2(DIV_STEPS);
  localparam int REM_W    = ROM_W + FRAC_SH + 1;

  localparam logic [ROM_W-1:0] NTC_ROM [TABLE_ENTRIES] = '{
    16'hF41B,
    16'hF370, 16'hF2BE, 16'hF203, 16'hF141, 16'hF076, 16'hEFA3, 16'hEEC7, 16'hEDE1,
    16'hECF3, 16'hEBFB,
    16'hEAFA, 16'hE9EF, 16'hE8DA, 16'hE7BB, 16'hE691, 16'hE55D, 16'hE41F, 16'hE2D5,
    16'hE181, 16'hE024,
    16'hDEB8, 16'hDD43, 16'hDBC2, 16'hDA37, 16'hD89F, 16'hD6FE, 16'hD552, 16'hD39A,
    16'hD1D7, 16'hD009,
    16'hCE32, 16'hCC50, 16'hCA63, 16'hC86D, 16'hC66D, 16'hC463, 16'hC250, 16'hC034,
    16'hBE0F, 16'hBBE5,
    16'hB9AE, 16'hB772, 16'hB52E, 16'hB2E4, 16'hB096, 16'hAE3F, 16'hABE3, 16'hA983,
    16'hA71E, 16'hA4B7,
    16'hA249, 16'h9FDB, 16'h9D69, 16'h9AF6, 16'h987F, 16'h960A, 16'h9393, 16'h911D,
    16'h8EA6, 16'h8C2F,
    16'h89BB, 16'h8748, 16'h84D8, 16'h826A, 16'h8000, 16'h7D99, 16'h7B36, 16'h78D7,
    16'h767D, 16'h7429,
    16'h71D7, 16'h6F8E, 16'h6D49, 16'h6B0A, 16'h68D7, 16'h66A4, 16'h6478, 16'h6258,
    16'h603D, 16'h5E2D,
    16'h5C1E, 16'h5A19, 16'h581E, 16'h562B, 16'h5441, 16'h525B, 16'h5080, 16'h4EAD,
    16'h4CE4, 16'h4B21,
    16'h496A, 16'h47B8, 16'h460F, 16'h4470, 16'h42D8, 16'h4148, 16'h3FC3, 16'h3E44,
    16'h3CCD, 16'h3B5D,
    16'h39F7, 16'h3897, 16'h373F, 16'h35EE, 16'h34A9, 16'h3365, 16'h322D, 16'h30FB,
    16'h2FCD, 16'h2EAD,
    16'h2D8F, 16'h2C76, 16'h2B64, 16'h2A5D, 16'h295C, 16'h285D, 16'h2766, 16'h2671,
    16'h2588, 16'h24AB,
    16'h23BF, 16'h22E4, 16'h2211, 16'h213C, 16'h2070, 16'h1FAC, 16'h1EE7, 16'h1E2B,
    16'h1D6E, 16'h1CBA,
    16'h1C0A, 16'h1B5E, 16'h1AB6, 16'h1A12, 16'h1973, 16'h18D3, 16'h183D, 16'h17A7,
    16'h1715, 16'h168D,
    16'h15FF, 16'h157B, 16'h14F7, 16'h1477, 16'h1403, 16'h1388, 16'h1312, 16'h12A2,
    16'h1231, 16'h11C5,
    16'h1159, 16'h10F2, 16'h108B, 16'h102A, 16'h0FCE, 16'h0F6B, 16'h0F0F, 16'h0EB7,
    16'h0E60, 16'h0E14
  };

endpackage

// ===== rtl/ntc_table_temperature_convert.sv =====
// Top level of the thermistor reading to temperature converter.
// Binary search over the calibration ROM, then, for a reading between two entries, interpolation through ntc_frac_div.
// Depends on ntc_pkg and ntc_frac_div.
// The search loop makes one ROM probe per cycle, at most eight probes and a closing step,
// and a reading between two entries then runs the divider before the result strobe.
// One transaction at a time: start_i is taken only in idle; busy_o drops in the strobe cycle.
// Reset clears the sequencer and the strobe; the receiver cannot stall a result.
module ntc_table_temperature_convert (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [ntc_pkg::RAW_W-1:0]          raw_reading_i,
  output logic                               valid_o,
  output logic signed [ntc_pkg::TEMP_W-1:0]  temperature_o
);
  import ntc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DIVIDE = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [X_W-1:0]     x_q, x_d;
  logic [IDX_W-1:0]   lo_q, lo_d;
  logic [IDX_W-1:0]   hi_q, hi_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               valid_q, valid_d;
  logic [TEMP_W-1:0]  temp_q, temp_d;

  logic [IDX_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid;
  logic [IDX_W-1:0]   mid_p1;
  logic [ROM_W-1:0]   rom_a;
  logic [ROM_W-1:0]   rom_b;
  logic               div_start;
  logic               div_done;
  logic [FRAC_W-1:0]  div_quot;

  function automatic logic [TEMP_W-1:0] to_temp(logic [IDX_W-1:0] idx,
                                                logic [FRAC_W-1:0] frac);
    logic [TEMP_W-1:0] base;
    base = TEMP_W'(idx) << FRAC_SH;
    return base + TEMP_W'(FIRST_DEGREE * (1 << FRAC_SH)) + TEMP_W'(frac);
  endfunction

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IDX_W:1];
  assign mid_p1  = mid + 1'b1;
  assign rom_a   = NTC_ROM[mid];
  assign rom_b   = NTC_ROM[mid_p1];

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    idx_d     = idx_q;
    valid_d   = 1'b0;
    temp_d    = temp_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_d     = {raw_reading_i, {FRAC_SH{1'b0}}};
          lo_d    = '0;
          hi_d    = IDX_W'(TABLE_ENTRIES - 1);
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!((lo_q + 1'b1) < hi_q)) begin
          idx_d   = (hi_q <= IDX_W'(1)) ? '0 : IDX_W'(TABLE_ENTRIES);
          temp_d  = to_temp(idx_d, '0);
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else if (x_q > rom_a) begin
          hi_d = mid;
        end else if (x_q < rom_a) begin
          if (x_q < rom_b) begin
            lo_d = mid;
          end else begin
            idx_d     = mid;
            div_start = 1'b1;
            state_d   = S_DIVIDE;
          end
        end else begin
          idx_d   = mid;
          temp_d  = to_temp(mid, '0);
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          temp_d  = to_temp(idx_q, div_quot);
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  ntc_frac_div u_frac_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rom_a - x_q),
    .den_i   (rom_a - rom_b),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    idx_q  <= idx_d;
    temp_q <= temp_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign temperature_o = temp_q;

endmodule

// ===== rtl/ntc_frac_div.sv =====
// Restoring divider that produces the interpolation fraction, one quotient bit a cycle.
// Computes ((a - x) << 4) / (a - b) for a reading inside one table segment.
// Depends on ntc_pkg.
module ntc_frac_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ntc_pkg::ROM_W-1:0]    num_i,
  input  logic [ntc_pkg::ROM_W-1:0]    den_i,
  output logic                         done_o,
  output logic [ntc_pkg::FRAC_W-1:0]   quot_o
);
  import ntc_pkg::*;

  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [REM_W-1:0]  dsh_q, dsh_d;
  logic [FRAC_W-1:0] quot_q, quot_d;
  logic              fits;

  assign fits = (rem_q >= dsh_q);

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    step_d   = step_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    quot_d   = quot_q;
    if (start_i) begin
      active_d = 1'b1;
      step_d   = '0;
      rem_d    = REM_W'({num_i, {FRAC_SH{1'b0}}});
      dsh_d    = REM_W'({den_i, {FRAC_SH{1'b0}}});
      quot_d   = '0;
    end else if (active_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[FRAC_W-2:0], fits};
      dsh_d  = dsh_q >> 1;
      if (step_q == STEP_W'(DIV_STEPS - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== dv/tb_ntc_table_temperature_convert.sv =====
// Testbench for ntc_table_temperature_convert: directed and random thermistor readings,
// each checked against a table search and interpolation predictor in the scoreboard.
// Depends on ntc_pkg and the RTL of the converter.
`timescale 1ns / 100ps

module tb_ntc_table_temperature_convert;

  import ntc_pkg::*;

  typedef struct {
    logic        [RAW_W-1:0]  raw;
    logic signed [TEMP_W-1:0] temp;
  } temp_expect_t;

  class temperature_scoreboard;
    temp_expect_t pending_temps[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic signed [TEMP_W-1:0] predict_temperature(logic [RAW_W-1:0] raw);
      int unsigned x;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned a;
      int unsigned b;
      int unsigned idx;
      int unsigned frac;
      bit          found;
      int          t;
      x     = {raw, 4'b0000};
      lo    = 0;
      hi    = TABLE_ENTRIES - 1;
      idx   = 0;
      frac  = 0;
      found = 1'b0;
      while (!found && lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        a   = NTC_ROM[mid];
        if (x > a) begin
          hi = mid;
        end else if (x < a) begin
          b = (mid + 1 < TABLE_ENTRIES) ? NTC_ROM[mid + 1] : 0;
          if (x < b) begin
            lo = mid;
          end else begin
            frac  = (a != b) ? (((a - x) << 4) / (a - b)) : 0;
            idx   = mid;
            found = 1'b1;
          end
        end else begin
          idx   = mid;
          found = 1'b1;
        end
      end
      if (!found) begin
        idx  = (hi <= 1) ? 0 : TABLE_ENTRIES;
        frac = 0;
      end
      t = (int'(idx) + FIRST_DEGREE) * 16 + int'(frac);
      return t[TEMP_W-1:0];
    endfunction

    function void note_reading(logic [RAW_W-1:0] raw);
      temp_expect_t e;
      e.raw  = raw;
      e.temp = predict_temperature(raw);
      pending_temps.push_back(e);
    endfunction

    function void check_temperature(logic signed [TEMP_W-1:0] actual);
      temp_expect_t e;
      if (pending_temps.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
      end else begin
        e = pending_temps.pop_front();
        if (actual !== e.temp) begin
          mismatches++;
          $display("%0t: temperature for reading 0x%03h: expected %0d, actual %0d",
                   $time, e.raw, e.temp, actual);
        end
      end
    endfunction

    function int pending();
      return pending_temps.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic        [RAW_W-1:0]  raw_reading_i;
  logic                     valid_o;
  logic signed [TEMP_W-1:0] temperature_o;

  temperature_scoreboard sb;

  ntc_table_temperature_convert dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .raw_reading_i (raw_reading_i),
    .valid_o       (valid_o),
    .temperature_o (temperature_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_temperature(temperature_o);
    end
  end

  task automatic send_reading(logic [RAW_W-1:0] raw);
    @(negedge clk_i);
    start_i       <= 1'b1;
    raw_reading_i <= raw;
    do @(posedge clk_i); while (busy_o);
    sb.note_reading(raw);
  endtask

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic drain_results();
    idle_for(1);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    logic [RAW_W-1:0] directed_readings[$];
    logic [RAW_W-1:0] raw;
    int               sent;
    int               burst;
    int               gap;
    int               wait_cycles;
    sb            = new();
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    raw_reading_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    idle_for(3);

    // Table ends, the clamp between the first two entries, exact entry hits
    // and the region past the last entry.
    directed_readings = '{12'h000, 12'hFFF, 12'hF42, 12'hF41, 12'hF38, 12'hF37, 12'hF36,
                          12'hF2B, 12'hEC0, 12'h800, 12'h7FF, 12'h801, 12'h555,
                          12'hAAA, 12'h0E6, 12'h0E5, 12'h0E2, 12'h0E1, 12'h0E0,
                          12'h001, 12'h100, 12'h3C0, 12'hA24, 12'h24A, 12'hDB0};
    foreach (directed_readings[i]) begin
      send_reading(directed_readings[i]);
    end
    drain_results();

    sent = 0;
    while (sent < 900) begin
      burst = $urandom_range(12, 1);
      repeat (burst) begin
        case ($urandom_range(9))
          0, 1:    raw = RAW_W'($urandom_range(4095));
          2:       raw = RAW_W'($urandom_range(12'hFFF, 12'hF30));
          3:       raw = RAW_W'($urandom_range(12'h0F0, 12'h000));
          default: raw = RAW_W'($urandom_range(12'hF42, 12'h0E0));
        endcase
        send_reading(raw);
        sent++;
      end
      if (sent % 150 < burst) begin
        drain_results();
      end else if ($urandom_range(3) != 0) begin
        gap = $urandom_range(8);
        idle_for(gap);
      end
    end

    idle_for(1);
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 2000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (40) @(negedge clk_i);
    while (sb.pending() != 0) begin
      void'(sb.pending_temps.pop_front());
      sb.mismatches++;
      $display("%0t: expected result never arrived, expected 1, actual 0", $time);
    end
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
